// ===== hdl/bfm_pkg.sv =====
// bfm_pkg: shared types and constants for the binary32 multiplier
// no dependencies

package bfm_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // per-item classification and unpacked operands after stage one
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [4:0]  lza;
        logic [4:0]  lzb;
        logic [7:0]  ea;
        logic [7:0]  eb;
    } t_unpacked;

    // count leading zeros of a 24-bit value (at most 23 for nonzero)
    function automatic logic [4:0] clz24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/bfm_round.sv =====
// bfm_round: normalization and round-to-nearest-even of the 48-bit product
// depends on bfm_pkg

module bfm_round
    import bfm_pkg::*;
(
    input  logic [47:0] i_p,
    input  logic [10:0] i_e,
    input  logic        i_sign,
    output logic [31:0] o_result
);

    logic [47:0]        p_n;
    logic signed [10:0] e_n;
    logic [5:0]         shift;
    logic [47:0]        q, rem, half;
    logic [24:0]        qr;
    logic signed [11:0] s;
    logic               tiny;

    always_comb begin
        e_n = $signed(i_e);
        if (i_p[47]) begin
            p_n = i_p;
            e_n = $signed(i_e) + 11'sd1;
        end else begin
            p_n = {i_p[46:0], 1'b0};
        end
        s = 12'sd25 - 12'(e_n);
        // far below half the smallest subnormal: always rounds to zero
        tiny = 1'b0;
        if (e_n >= 11'sd1) begin
            shift = 6'd24;
        end else if (s > 12'sd48) begin
            shift = 6'd48;
            tiny  = 1'b1;
        end else begin
            shift = s[5:0];
        end
        q    = (shift == 6'd48) ? 48'd0 : (p_n >> shift);
        half = 48'd1 << (shift - 6'd1);
        rem  = (shift == 6'd48) ? p_n : (p_n & ((48'd1 << shift) - 48'd1));
        qr   = q[24:0];
        if (!tiny && (rem > half || (rem == half && q[0]))) qr = q[24:0] + 25'd1;
        if (e_n >= 11'sd255) begin
            o_result = {i_sign, EXP_MAX, 23'd0};
        end else if (e_n >= 11'sd1) begin
            if (qr[24]) begin
                if (e_n + 11'sd1 >= 11'sd255) o_result = {i_sign, EXP_MAX, 23'd0};
                else o_result = {i_sign, 8'(e_n + 11'sd1), qr[23:1]};
            end else begin
                o_result = {i_sign, e_n[7:0], qr[22:0]};
            end
        end else begin
            o_result = {i_sign, 7'd0, qr[23:0]};
        end
    end

endmodule

// ===== hdl/binary32_float_multiplier.sv =====
// binary32_float_multiplier: ieee 754 single precision multiply, round to nearest even
// one transfer per cycle while the pipe is not stalled
// stages: unpack/classify, normalize subnormals, 24x24 multiply, round and pack
// a stall freezes the full stages at the head of the pipe; bubbles collapse while the output waits
// synchronous active-low reset clears only the valid bits
// depends on bfm_pkg and bfm_round

module binary32_float_multiplier
    import bfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product
);

    // valid bits of the four stages
    logic [3:0] r_v;
    logic [3:0] adv;

    // stage advance: a stage loads when it is empty or its successor is empty or moving
    always_comb begin
        adv[3] = !r_v[3] || !i_stall;
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end
    assign o_stall = !adv[0];

    // stage one: classify specials, split fields
    t_unpacked  r_s1, n_s1;
    logic [7:0] ea, eb;
    logic [22:0] fa, fb;
    logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;

    always_comb begin
        ea = i_op_a[30:23];
        eb = i_op_b[30:23];
        fa = i_op_a[22:0];
        fb = i_op_b[22:0];
        sgn = i_op_a[31] ^ i_op_b[31];
        nan_a = (ea == EXP_MAX) && (fa != 23'd0);
        nan_b = (eb == EXP_MAX) && (fb != 23'd0);
        inf_a = (ea == EXP_MAX) && (fa == 23'd0);
        inf_b = (eb == EXP_MAX) && (fb == 23'd0);
        zero_a = i_op_a[30:0] == 31'd0;
        zero_b = i_op_b[30:0] == 31'd0;
        n_s1.sign = sgn;
        n_s1.special = 1'b1;
        if (nan_a || nan_b) n_s1.special_val = QNAN_BITS;
        else if (inf_a || inf_b)
            n_s1.special_val = (zero_a || zero_b) ? QNAN_BITS : {sgn, EXP_MAX, 23'd0};
        else if (zero_a || zero_b) n_s1.special_val = {sgn, 31'd0};
        else begin
            n_s1.special = 1'b0;
            n_s1.special_val = 32'd0;
        end
        n_s1.ma  = {(ea != 8'd0), fa};
        n_s1.mb  = {(eb != 8'd0), fb};
        n_s1.lza = clz24({(ea != 8'd0), fa});
        n_s1.lzb = clz24({(eb != 8'd0), fb});
        // subnormal exponent reads as one
        n_s1.ea  = (ea == 8'd0) ? 8'd1 : ea;
        n_s1.eb  = (eb == 8'd0) ? 8'd1 : eb;
    end

    // stage two: normalize significands, combine exponents
    logic        r_sp2, r_sg2;
    logic [31:0] r_spv2;
    logic [23:0] r_ma2, r_mb2;
    logic [10:0] r_e2;

    // stage three: significand product
    logic        r_sp3, r_sg3;
    logic [31:0] r_spv3;
    logic [47:0] r_p3;
    logic [10:0] r_e3;

    // stage four: output register
    logic [31:0] r_out;
    logic [31:0] rounded;

    bfm_round u_round (
        .i_p      (r_p3),
        .i_e      (r_e3),
        .i_sign   (r_sg3),
        .o_result (rounded)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) r_s1 <= n_s1;
        if (adv[1]) begin
            r_sp2  <= r_s1.special;
            r_spv2 <= r_s1.special_val;
            r_sg2  <= r_s1.sign;
            r_ma2  <= r_s1.ma << r_s1.lza;
            r_mb2  <= r_s1.mb << r_s1.lzb;
            r_e2   <= 11'({3'd0, r_s1.ea}) + 11'({3'd0, r_s1.eb})
                      - 11'({6'd0, r_s1.lza}) - 11'({6'd0, r_s1.lzb}) - 11'd127;
        end
        if (adv[2]) begin
            r_sp3  <= r_sp2;
            r_spv3 <= r_spv2;
            r_sg3  <= r_sg2;
            r_p3   <= 48'(r_ma2) * 48'(r_mb2);
            r_e3   <= r_e2;
        end
        if (adv[3]) r_out <= r_sp3 ? r_spv3 : rounded;
    end

    assign o_valid   = r_v[3];
    assign o_product = r_out;

endmodule
